FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/irpdc_pkg.sv
package irpdc_pkg;

  // Default dictionary depth.
  localparam int DICT_DEPTH_DEF = 16;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION = 1'b0,
    REG_FUDGE     = 1'b1
  } cfg_reg_t;

  // Percentage arithmetic.
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [6:0] FUDGE_MAX = 7'd100;
  localparam int         BOUND_W   = 24;

  typedef struct packed {
    logic [15:0] on_value;
    logic [15:0] off_value;
  } pair_t;

  typedef struct packed {
    logic        start_of_code;
    logic        is_reference;
    logic [4:0]  code_index;
    logic [15:0] on_value;
    logic [15:0] off_value;
  } item_t;

  typedef struct packed {
    logic        out_is_reference;
    logic [4:0]  out_index;
    logic [15:0] out_on;
    logic [15:0] out_off;
    logic        separator_before;
    logic        bad_reference;
  } result_t;

  // Bound loading control from the sequencer to the match unit.
  typedef struct packed {
    logic load;
    logic sel_off;
  } bound_ctl_t;

  // Multiply a 16-bit duration by 100 with shifts and adds.
  function automatic logic [BOUND_W-1:0] times_100(input logic [15:0] v);
    logic [BOUND_W-1:0] x;
    x = {8'd0, v};
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

FILE: hdl/irpdc_dict.sv
module irpdc_dict #(
  parameter int  DEPTH = irpdc_pkg::DICT_DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  irpdc_pkg::pair_t     wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output irpdc_pkg::pair_t     rd_data
);
  import irpdc_pkg::*;

  pair_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/irpdc_match.sv
module irpdc_match (
  input  logic                  clk,
  input  irpdc_pkg::bound_ctl_t ctl,
  input  irpdc_pkg::pair_t      probe,
  input  logic [6:0]            fudge,
  input  irpdc_pkg::pair_t      entry,
  output logic                  hit
);
  import irpdc_pkg::*;

  logic [6:0]         f_sat;
  logic [6:0]         lo_pct;
  logic [15:0]        v;
  logic [22:0]        prod;
  logic [BOUND_W-1:0] v200;
  logic [BOUND_W-1:0] lo_bound;
  logic [BOUND_W-1:0] hi_bound;
  logic [BOUND_W-1:0] lo_on;
  logic [BOUND_W-1:0] hi_on;
  logic [BOUND_W-1:0] lo_off;
  logic [BOUND_W-1:0] hi_off;
  logic [BOUND_W-1:0] s_on;
  logic [BOUND_W-1:0] s_off;
  logic               hit_on;
  logic               hit_off;

  // Clamp tolerance to one hundred percent
  assign f_sat  = (fudge > FUDGE_MAX) ? FUDGE_MAX : fudge;
  assign lo_pct = PCT_SCALE - f_sat;

  // Scaled bounds v*(100-f) and v*(100+f) = 200v - v*(100-f), one value per cycle
  assign v        = ctl.sel_off ? probe.off_value : probe.on_value;
  assign prod     = {7'd0, v} * {16'd0, lo_pct};
  assign v200     = ({8'd0, v} << 7) + ({8'd0, v} << 6) + ({8'd0, v} << 3);
  assign lo_bound = {1'b0, prod};
  assign hi_bound = v200 - {1'b0, prod};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.sel_off) begin
        lo_off <= lo_bound;
        hi_off <= hi_bound;
      end else begin
        lo_on <= lo_bound;
        hi_on <= hi_bound;
      end
    end
  end

  // floor(a/100) <= s <= floor(b/100) is 100s+99 >= a and 100s <= b
  assign s_on    = times_100(entry.on_value);
  assign s_off   = times_100(entry.off_value);
  assign hit_on  = ((s_on + BOUND_W'(99)) >= lo_on) && (s_on <= hi_on);
  assign hit_off = ((s_off + BOUND_W'(99)) >= lo_off) && (s_off <= hi_off);
  assign hit     = hit_on && hit_off;

endmodule

FILE: hdl/ir_pair_dictionary_codec_top.sv
// IR pair dictionary codec.
// Input channel item/item_valid/item_ready carries one timing pair or token;
// output channel result/result_valid/result_ready returns exactly one result
// per item, in order. direction and fudge_percent are set through the plain
// write port cfg_we/cfg_index/cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Encode: the pair is searched first-match over the stored entries, one entry
// per cycle out of the dictionary memory, once the S_BOUND_ON and S_BOUND_OFF
// states scale the tolerance bounds. The search uses the memory's single read
// port; a new item is taken once the last result is in the output register.
// Decode: a reference makes one memory read and passes S_DREAD on its way to
// S_FINISH; a literal or a bad reference goes straight to S_FINISH.
// Reset clears the entry count, the separator flag and the configuration;
// the dictionary memory itself is not cleared, as only counted entries are
// ever read. start_of_code empties the dictionary before its item.
// A stalled receiver holds the result in the output register; the block
// still accepts and works on one more item, then waits to hand it over.
`include "assert_macros.svh"

module ir_pair_dictionary_codec_top #(
  parameter int  DICT_DEPTH = irpdc_pkg::DICT_DEPTH_DEF,
  localparam int IDX_W      = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1,
  localparam int CNT_W      = $clog2(DICT_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [irpdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpdc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  irpdc_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output irpdc_pkg::result_t                 result
);
  import irpdc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_BOUND_ON  = 6'b000010,
    S_BOUND_OFF = 6'b000100,
    S_SEARCH    = 6'b001000,
    S_DREAD     = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t             state;
  logic               direction;
  logic [6:0]         fudge_percent;
  item_t              it;
  result_t            res;
  logic               store_pending;
  logic [CNT_W-1:0]   entry_count;
  logic               last_was_literal;
  logic [CNT_W-1:0]   rd_idx;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;

  logic               accept;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_eff;
  logic               idx_ok;
  logic               dec_ref_read;
  logic               search_rd;
  logic               hit;
  logic               last_cmp;
  logic               wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  pair_t              wr_data;
  pair_t              rd_data;
  pair_t              probe;
  bound_ctl_t         bctl;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Entry count as seen by this item, after an optional restart
  assign cnt_eff      = item.start_of_code ? '0 : entry_count;
  assign idx_ok       = ({1'b0, item.code_index} < 6'(cnt_eff));
  assign dec_ref_read = accept && direction && item.is_reference && idx_ok;
  assign search_rd    = (state == S_SEARCH) && (rd_idx < entry_count);
  assign last_cmp     = cmp_valid && ((CNT_W'(cmp_idx) + CNT_W'(1)) == entry_count);

  // Memory port selection
  assign rd_en   = dec_ref_read || search_rd;
  assign rd_addr = dec_ref_read ? item.code_index[IDX_W-1:0] : rd_idx[IDX_W-1:0];
  assign wr_en   = (state == S_FINISH) && out_free && store_pending &&
                   (entry_count < CNT_W'(DICT_DEPTH));
  assign wr_data = '{on_value: it.on_value, off_value: it.off_value};

  // Bound scaling control
  assign bctl  = '{load:    (state == S_BOUND_ON) || (state == S_BOUND_OFF),
                   sel_off: (state == S_BOUND_OFF)};
  assign probe = '{on_value: it.on_value, off_value: it.off_value};

  irpdc_dict #(
    .DEPTH (DICT_DEPTH)
  ) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  irpdc_match u_match (
    .clk   (clk),
    .ctl   (bctl),
    .probe (probe),
    .fudge (fudge_percent),
    .entry (rd_data),
    .hit   (hit)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      fudge_percent <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION: direction     <= cfg_data[0];
        REG_FUDGE:     fudge_percent <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Item latch and pending result: payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      it <= item;
      if (!direction) begin
        res <= '0;
      end else if (item.is_reference) begin
        res <= '{out_is_reference: 1'b1, out_index: item.code_index, out_on: 16'd0,
                 out_off: 16'd0, separator_before: 1'b0, bad_reference: !idx_ok};
      end else begin
        res <= '{out_is_reference: 1'b0, out_index: 5'd0, out_on: item.on_value,
                 out_off: item.off_value, separator_before: 1'b0, bad_reference: 1'b0};
      end
    end else if (state == S_DREAD) begin
      res.out_on  <= rd_data.on_value;
      res.out_off <= rd_data.off_value;
    end else if (state == S_SEARCH) begin
      if (cmp_valid && hit) begin
        res <= '{out_is_reference: 1'b1, out_index: 5'(cmp_idx), out_on: 16'd0,
                 out_off: 16'd0, separator_before: 1'b0, bad_reference: 1'b0};
      end else if ((entry_count == '0) || last_cmp) begin
        res <= '{out_is_reference: 1'b0, out_index: 5'd0, out_on: it.on_value,
                 out_off: it.off_value, separator_before: last_was_literal,
                 bad_reference: 1'b0};
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      entry_count      <= '0;
      last_was_literal <= 1'b0;
      store_pending    <= 1'b0;
      rd_idx           <= '0;
      cmp_valid        <= 1'b0;
      cmp_idx          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.start_of_code) begin
              entry_count      <= '0;
              last_was_literal <= 1'b0;
            end
            if (!direction) begin
              state <= S_BOUND_ON;
            end else if (item.is_reference) begin
              store_pending <= 1'b0;
              state         <= idx_ok ? S_DREAD : S_FINISH;
            end else begin
              store_pending <= 1'b1;
              state         <= S_FINISH;
            end
          end
        end
        S_BOUND_ON: begin
          state <= S_BOUND_OFF;
        end
        S_BOUND_OFF: begin
          rd_idx    <= '0;
          cmp_valid <= 1'b0;
          state     <= S_SEARCH;
        end
        S_SEARCH: begin
          if (cmp_valid && hit) begin
            last_was_literal <= 1'b0;
            store_pending    <= 1'b0;
            state            <= S_FINISH;
          end else if ((entry_count == '0) || last_cmp) begin
            last_was_literal <= 1'b1;
            store_pending    <= 1'b1;
            state            <= S_FINISH;
          end else if (search_rd) begin
            // advance the read one entry ahead of the compare
            rd_idx    <= rd_idx + CNT_W'(1);
            cmp_valid <= 1'b1;
            cmp_idx   <= rd_idx[IDX_W-1:0];
          end
        end
        S_DREAD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            if (wr_en) begin
              entry_count <= entry_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if ((state == S_FINISH) && out_free) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      result <= res;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, entry_count <= CNT_W'(DICT_DEPTH), "count overflow")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, accept, !item_ready, "accepted while busy")
  `ASSERT_IMPLIES(a_cmp_in_range, clk, rst, (state == S_SEARCH) && cmp_valid, CNT_W'(cmp_idx) < entry_count, "compare beyond count")
  `ASSERT_IMPLIES(a_bad_zero, clk, rst, result_valid && result.bad_reference, result.out_on == 16'd0 && result.out_off == 16'd0 && result.out_is_reference, "bad reference carries data")

endmodule
